// ===== design/dtbp_pkg.sv =====
// Package for the two-bit DNA packer: constants, result kind codes,
// base decode function and the push control struct.
// No dependencies.
package dtbp_pkg;

  // Default width of positions and counts
  localparam int POS_WIDTH_DEF = 31;

  // Result kind codes
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_RANGE = 1'b1;

  // Two-bit base codes
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Fill level at which a byte is complete (four bases, 0..3)
  localparam logic [1:0] LAST_SLOT = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  // Core to output queue: load marks a consumed item, first/second
  // mark how many results it left
  typedef struct packed {
    logic load;
    logic first;
    logic second;
  } push_t;

  // Decode one ASCII character into a base code
  function automatic base_t base_code(input logic [7:0] ch);
    base_t b;
    b.ok   = 1'b1;
    b.code = CODE_A;
    case (ch) inside
      8'h41, 8'h61: b.code = CODE_A;
      8'h43, 8'h63: b.code = CODE_C;
      8'h47, 8'h67: b.code = CODE_G;
      8'h54, 8'h74: b.code = CODE_T;
      default:      b.ok   = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== design/dtbp_if.sv =====
// Channel interfaces of the two-bit DNA packer: character input and
// result output, valid/ready handshake. Depends on dtbp_pkg.
interface dtbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       is_final;

  modport source (output valid, base_char, is_final, input ready);
  modport sink   (input valid, base_char, is_final, output ready);
endinterface

interface dtbp_out_if #(
  parameter int POS_WIDTH = dtbp_pkg::POS_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [7:0]           packed_byte;
  logic [POS_WIDTH-1:0] run_start;
  logic [POS_WIDTH-1:0] run_end;
  logic [POS_WIDTH-1:0] valid_total;
  logic                 end_of_run;

  modport source (output valid, kind, packed_byte, run_start, run_end, valid_total,
                  end_of_run, input ready);
  modport sink   (input valid, kind, packed_byte, run_start, run_end, valid_total,
                  end_of_run, output ready);
endinterface

// ===== design/dtbp_in_reg.sv =====
// Input register of the two-bit DNA packer: holds one character until
// the core takes it. Uses dtbp_in_if.
module dtbp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  dtbp_in_if.sink    in_if,
  input  logic       take,
  output logic       item_vld,
  output logic [7:0] item_char,
  output logic       item_final
);

  logic       vld_r;
  logic [7:0] char_r;
  logic       fin_r;

  // Free when empty or when the held item leaves this cycle
  assign in_if.ready = !vld_r || take;

  // Load on transfer, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_if.ready) begin
      vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      char_r <= in_if.base_char;
      fin_r  <= in_if.is_final;
    end
  end

  assign item_vld   = vld_r;
  assign item_char  = char_r;
  assign item_final = fin_r;

endmodule

// ===== design/dtbp_core.sv =====
// Packing core: sequence state, base packing, run tracking and final
// flush. Produces up to two results per item. Uses dtbp_pkg.
module dtbp_core #(
  parameter int POS_WIDTH = dtbp_pkg::POS_WIDTH_DEF,
  localparam int ResW = 3 * POS_WIDTH + 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      base_char,
  input  logic            is_final,
  output dtbp_pkg::push_t push,
  output logic [ResW-1:0] res0,
  output logic [ResW-1:0] res1
);

  typedef struct packed {
    logic                 kind;
    logic [7:0]           packed_byte;
    logic [POS_WIDTH-1:0] run_start;
    logic [POS_WIDTH-1:0] run_end;
    logic [POS_WIDTH-1:0] valid_total;
    logic                 end_of_run;
  } res_t;

  logic [7:0]           buf_r, buf_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] ors_r, ors_nxt;
  logic [POS_WIDTH-1:0] vcnt_r, vcnt_nxt;

  dtbp_pkg::base_t      bc;
  logic [POS_WIDTH-1:0] pos_inc;
  logic [7:0]           buf_sh;
  res_t                 emit [4];
  logic [3:0]           emit_vld;
  res_t                 r0, r1;
  logic                 n_two;

  // Step the sequence state for one character
  always_comb begin
    bc       = dtbp_pkg::base_code(base_char);
    pos_inc  = pos_r + POS_WIDTH'(1);
    buf_sh   = {buf_r[5:0], bc.code};
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_inc;
    ors_nxt  = ors_r;
    vcnt_nxt = vcnt_r;
    emit_vld = '0;
    for (int i = 0; i < 4; i++) begin
      emit[i] = '0;
    end

    // The character itself: close a run, or pack a base
    if (!bc.ok) begin
      if (ors_r != pos_r) begin
        emit_vld[0]       = 1'b1;
        emit[0].kind      = dtbp_pkg::KIND_RANGE;
        emit[0].run_start = ors_r;
        emit[0].run_end   = pos_r;
      end
      ors_nxt = pos_inc;
    end else begin
      vcnt_nxt = vcnt_r + POS_WIDTH'(1);
      if (cnt_r == dtbp_pkg::LAST_SLOT) begin
        emit_vld[0]         = 1'b1;
        emit[0].kind        = dtbp_pkg::KIND_BYTE;
        emit[0].packed_byte = buf_sh;
        buf_nxt             = '0;
        cnt_nxt             = '0;
      end else begin
        buf_nxt = buf_sh;
        cnt_nxt = cnt_r + 2'd1;
      end
    end

    // Final flush: padded byte, open run, or an empty record
    if (is_final) begin
      emit[1].kind = dtbp_pkg::KIND_BYTE;
      case (cnt_nxt)
        2'd1:    emit[1].packed_byte = {buf_nxt[1:0], 6'b0};
        2'd2:    emit[1].packed_byte = {buf_nxt[3:0], 4'b0};
        2'd3:    emit[1].packed_byte = {buf_nxt[5:0], 2'b0};
        default: emit[1].packed_byte = '0;
      endcase
      emit_vld[1] = (cnt_nxt != 2'd0);
      if (ors_nxt != pos_inc) begin
        emit_vld[2]       = 1'b1;
        emit[2].kind      = dtbp_pkg::KIND_RANGE;
        emit[2].run_start = ors_nxt;
        emit[2].run_end   = pos_inc;
      end
      emit_vld[3]       = !(emit_vld[0] || emit_vld[1] || emit_vld[2]);
      emit[3].kind      = dtbp_pkg::KIND_RANGE;
      emit[3].run_start = pos_inc;
      emit[3].run_end   = pos_inc;
      buf_nxt  = '0;
      cnt_nxt  = '0;
      pos_nxt  = '0;
      ors_nxt  = '0;
    end

    for (int i = 0; i < 4; i++) begin
      emit[i].valid_total = vcnt_nxt;
    end
  end

  // Compact the candidates into two result slots; on a final item, mark the last one
  always_comb begin
    if (emit_vld[0]) begin
      r0 = emit[0];
      r1 = emit_vld[1] ? emit[1] : (emit_vld[2] ? emit[2] : emit[3]);
    end else if (emit_vld[1]) begin
      r0 = emit[1];
      r1 = emit_vld[2] ? emit[2] : emit[3];
    end else begin
      r0 = emit_vld[2] ? emit[2] : emit[3];
      r1 = emit[3];
    end
    n_two = (32'($countones(emit_vld)) > 32'd1);
    if (is_final) begin
      if (n_two) begin
        r1.end_of_run = 1'b1;
      end else begin
        r0.end_of_run = 1'b1;
      end
    end
  end

  assign push.load   = take;
  assign push.first  = take && (emit_vld != 4'b0);
  assign push.second = take && n_two;
  assign res0        = r0;
  assign res1        = r1;

  // Hold state, advance on each taken character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
      ors_r  <= '0;
      vcnt_r <= '0;
    end else if (take) begin
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      ors_r  <= ors_nxt;
      vcnt_r <= (is_final) ? '0 : vcnt_nxt;
    end
  end

endmodule

// ===== design/dtbp_out_queue.sv =====
// Two-slot result register of the two-bit DNA packer: takes up to two
// results at once and presents them one per transfer. Uses dtbp_pkg.
module dtbp_out_queue #(
  parameter int DataWidth = 3 * dtbp_pkg::POS_WIDTH_DEF + 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtbp_pkg::push_t      push,
  input  logic [DataWidth-1:0] d0,
  input  logic [DataWidth-1:0] d1,
  input  logic                 out_ready,
  output logic                 room,
  output logic                 head_vld,
  output logic [DataWidth-1:0] head
);

  logic                 v0_r, v1_r;
  logic [DataWidth-1:0] s0_r, s1_r;
  logic                 pop;

  // Room for a new item when the queue is empty or drains this cycle
  assign pop  = v0_r && out_ready;
  assign room = !v0_r || (pop && !v1_r);

  // Load both slots on a new item, shift on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (push.load) begin
      v0_r <= push.first;
      v1_r <= push.second;
    end else if (pop) begin
      v0_r <= v1_r;
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.load) begin
      s0_r <= d0;
      s1_r <= d1;
    end else if (pop) begin
      s0_r <= s1_r;
    end
  end

  assign head_vld = v0_r;
  assign head     = s0_r;

endmodule

// ===== design/dna_two_bit_packer.sv =====
// Top level of the two-bit DNA packer. Depends on dtbp_pkg, dtbp_if,
// dtbp_in_reg, dtbp_core and dtbp_out_queue.
//
//   channel  | direction | payload
//   in_if    | sink      | base_char[7:0], is_final
//   out_if   | source    | kind, packed_byte[7:0], run_start, run_end,
//            |           | valid_total (POS_WIDTH each), end_of_run
//
// One character per cycle enters the input register while the core takes
// the held one; the core handles it from there and loads up to two results
// into the two-slot output register. Items with one or no result sustain one
// per cycle while out_if.ready is high; an item with two results holds the
// next item until its second result is leaving through the single output port.
// Reset (synchronous, rst_n low) clears all sequence state; a final
// character also returns the state to reset. Output stalls back up into
// the input register and then to in_if.ready.
module dna_two_bit_packer #(
  parameter int POS_WIDTH = dtbp_pkg::POS_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dtbp_in_if.sink    in_if,
  dtbp_out_if.source out_if
);

  localparam int ResW = 3 * POS_WIDTH + 10;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           packed_byte;
    logic [POS_WIDTH-1:0] run_start;
    logic [POS_WIDTH-1:0] run_end;
    logic [POS_WIDTH-1:0] valid_total;
    logic                 end_of_run;
  } res_t;

  logic            item_vld;
  logic [7:0]      item_char;
  logic            item_final;
  logic            room;
  logic            take;
  dtbp_pkg::push_t push;
  logic [ResW-1:0] res0, res1, head;
  logic            head_vld;
  res_t            head_res;

  // Hand the held character to the core when the output register has room
  assign take = item_vld && room;

  dtbp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (take),
    .item_vld   (item_vld),
    .item_char  (item_char),
    .item_final (item_final)
  );

  dtbp_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .base_char (item_char),
    .is_final  (item_final),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  dtbp_out_queue #(
    .DataWidth (ResW)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .d0        (res0),
    .d1        (res1),
    .out_ready (out_if.ready),
    .room      (room),
    .head_vld  (head_vld),
    .head      (head)
  );

  // Drive the result channel from the head slot
  assign head_res           = head;
  assign out_if.valid       = head_vld;
  assign out_if.kind        = head_res.kind;
  assign out_if.packed_byte = head_res.packed_byte;
  assign out_if.run_start   = head_res.run_start;
  assign out_if.run_end     = head_res.run_end;
  assign out_if.valid_total = head_res.valid_total;
  assign out_if.end_of_run  = head_res.end_of_run;

  // Packed bytes carry no range
  a_byte_no_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld && head_res.kind == dtbp_pkg::KIND_BYTE
    |-> head_res.run_start == '0 && head_res.run_end == '0)
    else $error("packed byte result carries a range");

  // Range records carry no byte
  a_range_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld && head_res.kind == dtbp_pkg::KIND_RANGE |-> head_res.packed_byte == '0)
    else $error("range record carries a packed byte");

  // Only the closing record of a sequence may be an empty range
  a_empty_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld && head_res.kind == dtbp_pkg::KIND_RANGE && !head_res.end_of_run
    |-> head_res.run_start != head_res.run_end)
    else $error("empty range record before end of sequence");

  // The second result slot is filled only together with the first
  a_push_compact: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first && push.load)
    else $error("second result pushed without the first");

endmodule
